// File: sv/nearest_snap_point_search_assert.svh
// Assertion macros for the nearest snap point search block.
// Included by the top level; depends on nothing else.
`ifndef NEAREST_SNAP_POINT_SEARCH_ASSERT_SVH
`define NEAREST_SNAP_POINT_SEARCH_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle.
`define NSPS_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence in the following cycle.
`define NSPS_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// File: sv/nsps_pkg.sv
// Package for the nearest snap point search block: payload types, codes, states.
// Used by nsps_grid and nearest_snap_point_search; depends on nothing.
package nsps_pkg;

    localparam int TableDepth = 1024;
    localparam int AddrBits   = $clog2(TableDepth);
    localparam int CountBits  = AddrBits + 1;
    localparam int CoordBits  = 24;
    localparam int MeshBits   = 16;
    localparam int ElemBits   = 16;
    localparam int DistBits   = 50;
    localparam int StepBits   = 23;
    localparam int DiffBits   = CoordBits + 1;
    localparam int SqBits     = 2 * DiffBits;
    localparam int SumBits    = SqBits + 2;
    localparam int TagBits    = 2 + ElemBits + MeshBits;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        SK_NONE   = 3'd0,
        SK_VERTEX = 3'd1,
        SK_EDGE   = 3'd2,
        SK_FACE   = 3'd3,
        SK_GRID   = 3'd4
    } t_snap_kind;

    localparam logic [1:0] PK_VERTEX = 2'd0;
    localparam logic [1:0] PK_EDGE   = 2'd1;
    localparam logic [1:0] PK_FACE   = 2'd2;
    localparam logic [1:0] PK_BAD    = 2'd3;

    typedef enum logic [2:0] {
        CFG_SNAP_EN   = 3'd0,
        CFG_OBJ_EN    = 3'd1,
        CFG_VERT_EN   = 3'd2,
        CFG_EDGE_EN   = 3'd3,
        CFG_FACE_EN   = 3'd4,
        CFG_GRID_EN   = 3'd5,
        CFG_GRID_STEP = 3'd6,
        CFG_TOL       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]                  req_type;
        logic signed [CoordBits-1:0] pos_x;
        logic signed [CoordBits-1:0] pos_y;
        logic signed [CoordBits-1:0] pos_z;
        logic [1:0]                  point_kind;
        logic [MeshBits-1:0]         mesh_ident;
        logic [ElemBits-1:0]         element_number;
    } t_in_item;

    typedef struct packed {
        logic                        snapped;
        logic [2:0]                  snap_kind;
        logic signed [CoordBits-1:0] snap_x;
        logic signed [CoordBits-1:0] snap_y;
        logic signed [CoordBits-1:0] snap_z;
        logic [MeshBits-1:0]         hit_mesh;
        logic [ElemBits-1:0]         hit_element;
        logic [DistBits-1:0]         dist_sq;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RM_SCAN,
        ST_MAG,
        ST_DSQ,
        ST_SUM,
        ST_FETCH,
        ST_FETCH2,
        ST_GRID,
        ST_GSQ,
        ST_GSUM,
        ST_DONE
    } t_state;

    // Grid unit start / result handshake
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_grid_ctl;

endpackage

// File: sv/nearest_snap_point_search.sv
// Nearest snap point search: a table of up to 1024 snap points in on-chip
// memory. Load, clear and remove are transactions with no result; a query
// gives one result. A load or clear is done without leaving the idle state.
// A query reads the table one entry a cycle. After the query is accepted,
// the input stays stalled through the table scan, the drain of the
// three-stage squared-distance pipeline and a re-read of the best entry. On
// an object hit the query then finishes; otherwise it waits for the grid
// fallback. The grid fallback runs a 25-step divider and a multiply step per
// axis in parallel with the scan, then makes one more squared-distance pass.
// The result register is loaded from the done state; a stalled result delays
// the return to idle. A remove compacts the table in place with one read port
// and one write port.
// Depends on nsps_pkg, nsps_grid and nearest_snap_point_search_assert.svh.
`include "nearest_snap_point_search_assert.svh"
module nearest_snap_point_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  nsps_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output nsps_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [2:0]                      i_cfg_index,
    input  logic [nsps_pkg::StepBits-1:0]   i_cfg_data
);
    localparam int AB = nsps_pkg::AddrBits;
    localparam int CB = nsps_pkg::CountBits;
    localparam int WB = nsps_pkg::CoordBits;
    localparam int EW = 3 * WB + nsps_pkg::TagBits;

    // Configuration registers
    logic r_snap_en, r_obj_en, r_vert_en, r_edge_en, r_face_en, r_grid_en;
    logic [nsps_pkg::StepBits-1:0] r_grid_step, r_tol;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_en   <= 1'b1;
            r_obj_en    <= 1'b1;
            r_vert_en   <= 1'b1;
            r_edge_en   <= 1'b1;
            r_face_en   <= 1'b1;
            r_grid_en   <= 1'b1;
            r_grid_step <= nsps_pkg::StepBits'(4096);
            r_tol       <= nsps_pkg::StepBits'(2048);
        end else if (i_cfg_valid) begin
            unique case (nsps_pkg::t_cfg_idx'(i_cfg_index))
                nsps_pkg::CFG_SNAP_EN:   r_snap_en   <= i_cfg_data[0];
                nsps_pkg::CFG_OBJ_EN:    r_obj_en    <= i_cfg_data[0];
                nsps_pkg::CFG_VERT_EN:   r_vert_en   <= i_cfg_data[0];
                nsps_pkg::CFG_EDGE_EN:   r_edge_en   <= i_cfg_data[0];
                nsps_pkg::CFG_FACE_EN:   r_face_en   <= i_cfg_data[0];
                nsps_pkg::CFG_GRID_EN:   r_grid_en   <= i_cfg_data[0];
                nsps_pkg::CFG_GRID_STEP: r_grid_step <= i_cfg_data;
                nsps_pkg::CFG_TOL:       r_tol       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Point table: {x, y, z, tag}, tag = {mesh, element, kind}
    logic [EW-1:0] mem [nsps_pkg::TableDepth];
    logic [EW-1:0] r_rd_data;
    logic          w_we;
    logic [AB-1:0] w_wa, w_ra;
    logic [EW-1:0] w_wd;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        r_rd_data <= mem[w_ra];
    end

    logic signed [WB-1:0] rd_x, rd_y, rd_z;
    logic [1:0]           rd_kind;
    logic [nsps_pkg::ElemBits-1:0] rd_elem;
    logic [nsps_pkg::MeshBits-1:0] rd_mesh;
    assign {rd_x, rd_y, rd_z, rd_mesh, rd_elem, rd_kind} = r_rd_data;

    // Control state
    nsps_pkg::t_state r_state, n_state;
    logic [CB-1:0] r_fill, n_fill;
    logic [CB-1:0] r_rd_cnt, n_rd_cnt;   // entries issued for read
    logic [CB-1:0] r_wr_cnt, n_wr_cnt;   // compaction write pointer
    logic          r_rd_vld, n_rd_vld;   // read data valid this cycle
    logic [AB-1:0] r_rd_idx, n_rd_idx;   // index of data being returned
    nsps_pkg::t_in_item r_req;

    // Per-candidate distance pipeline: diff, square, sum
    logic          r_p1_vld, r_p2_vld, r_p3_vld;
    logic [AB-1:0] r_p1_idx, r_p2_idx, r_p3_idx;
    logic [1:0]    r_p1_k, r_p2_k, r_p3_k;
    logic [WB:0]   r_dx, r_dy, r_dz;
    logic [nsps_pkg::SqBits-1:0] r_sx, r_sy, r_sz;
    logic [nsps_pkg::SumBits-1:0] r_dsum;

    // Best candidate
    logic          r_found;
    logic [nsps_pkg::SumBits-1:0] r_best_d;
    logic [1:0]    r_best_k;
    logic [AB-1:0] r_best_i;
    logic [nsps_pkg::SqBits-1:0] r_tol2;

    // Grid path
    nsps_pkg::t_grid_ctl gctl_x, gctl_y, gctl_z;
    logic signed [WB-1:0] g_x, g_y, g_z;
    logic                 w_gstart;
    nsps_pkg::t_out_item  r_out, n_out;
    logic                 r_out_vld;

    logic w_accept, w_cand_ok, w_pipe_busy, w_keep;

    assign w_accept = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (rd_kind)
            nsps_pkg::PK_VERTEX: w_cand_ok = r_vert_en;
            nsps_pkg::PK_EDGE:   w_cand_ok = r_edge_en;
            nsps_pkg::PK_FACE:   w_cand_ok = r_face_en;
            default:             w_cand_ok = 1'b0;
        endcase
        w_cand_ok = w_cand_ok && (rd_mesh != r_req.mesh_ident);
    end
    assign w_keep      = rd_mesh != r_req.mesh_ident;
    assign w_pipe_busy = r_p1_vld | r_p2_vld | r_p3_vld;

    // Absolute difference of two signed coordinates
    function automatic logic [WB:0] f_absdiff(input logic signed [WB-1:0] a,
                                              input logic signed [WB-1:0] b);
        logic signed [WB:0] d;
        d = (WB+1)'(a) - (WB+1)'(b);
        return d[WB] ? (WB+1)'(-d) : d;
    endfunction

    // Next state and table port control
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_rd_cnt = r_rd_cnt;
        n_wr_cnt = r_wr_cnt;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_cnt[AB-1:0];
        w_we     = 1'b0;
        w_wa     = r_fill[AB-1:0];
        w_wd     = {i_in_data.pos_x, i_in_data.pos_y, i_in_data.pos_z,
                    i_in_data.mesh_ident, i_in_data.element_number, i_in_data.point_kind};
        // scan the table while reading; afterwards hold the best entry on the port
        w_ra     = (r_state == nsps_pkg::ST_SCAN || r_state == nsps_pkg::ST_RM_SCAN)
                 ? r_rd_cnt[AB-1:0] : r_best_i;
        w_gstart = 1'b0;
        unique case (r_state)
            nsps_pkg::ST_IDLE: begin
                n_rd_cnt = '0;
                n_wr_cnt = '0;
                if (w_accept) begin
                    unique case (nsps_pkg::t_req'(i_in_data.req_type))
                        nsps_pkg::REQ_CLEAR: n_fill = '0;
                        nsps_pkg::REQ_LOAD: begin
                            if (i_in_data.point_kind != nsps_pkg::PK_BAD &&
                                r_fill != CB'(nsps_pkg::TableDepth)) begin
                                w_we   = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        nsps_pkg::REQ_REMOVE: n_state = nsps_pkg::ST_RM_SCAN;
                        nsps_pkg::REQ_QUERY: begin
                            n_state  = nsps_pkg::ST_SCAN;
                            w_gstart = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            nsps_pkg::ST_SCAN: begin
                // issue one read a cycle; drain the pipeline at the end
                if (r_obj_en && r_rd_cnt < r_fill) begin
                    n_rd_vld = 1'b1;
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end else if (!r_rd_vld && !w_pipe_busy) begin
                    n_state = nsps_pkg::ST_FETCH;
                end
            end
            nsps_pkg::ST_RM_SCAN: begin
                // read ahead, write kept entries back at the write pointer
                if (r_rd_cnt < r_fill) begin
                    n_rd_vld = 1'b1;
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
                if (r_rd_vld && w_keep) begin
                    w_we     = 1'b1;
                    w_wa     = r_wr_cnt[AB-1:0];
                    w_wd     = r_rd_data;
                    n_wr_cnt = r_wr_cnt + 1'b1;
                end
                if (r_rd_cnt == r_fill && !r_rd_vld) begin
                    n_fill  = r_wr_cnt;
                    n_state = nsps_pkg::ST_IDLE;
                end
            end
            nsps_pkg::ST_FETCH: begin
                w_ra    = r_best_i;
                n_state = nsps_pkg::ST_FETCH2;
            end
            nsps_pkg::ST_FETCH2: n_state = nsps_pkg::ST_GRID;
            nsps_pkg::ST_GRID: begin
                if (r_found && r_best_d < nsps_pkg::SumBits'(r_tol2))
                    n_state = nsps_pkg::ST_DONE;
                else if (!gctl_x.busy && !gctl_x.start)
                    n_state = nsps_pkg::ST_MAG;
            end
            nsps_pkg::ST_MAG:  n_state = nsps_pkg::ST_GSQ;
            nsps_pkg::ST_GSQ:  n_state = nsps_pkg::ST_GSUM;
            nsps_pkg::ST_GSUM: n_state = nsps_pkg::ST_DONE;
            nsps_pkg::ST_DSQ:  n_state = nsps_pkg::ST_IDLE;
            nsps_pkg::ST_SUM:  n_state = nsps_pkg::ST_IDLE;
            nsps_pkg::ST_DONE: begin
                if (!r_out_vld || !i_out_stall) n_state = nsps_pkg::ST_IDLE;
            end
            default: n_state = nsps_pkg::ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != nsps_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nsps_pkg::ST_IDLE;
            r_fill   <= '0;
            r_rd_cnt <= '0;
            r_wr_cnt <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_rd_cnt <= n_rd_cnt;
            r_wr_cnt <= n_wr_cnt;
            r_rd_vld <= n_rd_vld;
        end
        r_rd_idx <= n_rd_idx;
        if (w_accept) begin
            r_req  <= i_in_data;
            r_tol2 <= nsps_pkg::SqBits'(r_tol) * nsps_pkg::SqBits'(r_tol);
        end
    end

    // Distance pipeline and running minimum over candidates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_p1_vld <= r_rd_vld && (r_state == nsps_pkg::ST_SCAN) && w_cand_ok;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            if (w_accept) begin
                r_found <= 1'b0;
            end else if (r_p3_vld) begin
                if (!r_found || r_dsum < r_best_d ||
                    (r_dsum == r_best_d && r_p3_k < r_best_k))
                    r_found <= 1'b1;
            end
        end
        // diff and square stages double for grid path in ST_MAG/ST_GSQ
        if (r_state == nsps_pkg::ST_MAG) begin
            r_dx <= f_absdiff(g_x, r_req.pos_x);
            r_dy <= f_absdiff(g_y, r_req.pos_y);
            r_dz <= f_absdiff(g_z, r_req.pos_z);
        end else begin
            r_dx <= f_absdiff(rd_x, r_req.pos_x);
            r_dy <= f_absdiff(rd_y, r_req.pos_y);
            r_dz <= f_absdiff(rd_z, r_req.pos_z);
        end
        r_p1_idx <= r_rd_idx;
        r_p1_k   <= rd_kind;
        r_sx     <= nsps_pkg::SqBits'(r_dx) * nsps_pkg::SqBits'(r_dx);
        r_sy     <= nsps_pkg::SqBits'(r_dy) * nsps_pkg::SqBits'(r_dy);
        r_sz     <= nsps_pkg::SqBits'(r_dz) * nsps_pkg::SqBits'(r_dz);
        r_p2_idx <= r_p1_idx;
        r_p2_k   <= r_p1_k;
        r_dsum   <= nsps_pkg::SumBits'(r_sx) + nsps_pkg::SumBits'(r_sy)
                  + nsps_pkg::SumBits'(r_sz);
        r_p3_idx <= r_p2_idx;
        r_p3_k   <= r_p2_k;
        if (r_p3_vld && (!r_found || r_dsum < r_best_d ||
            (r_dsum == r_best_d && r_p3_k < r_best_k))) begin
            r_best_d <= r_dsum;
            r_best_k <= r_p3_k;
            r_best_i <= r_p3_idx;
        end
    end

    nsps_grid u_grid_x (.i_clk, .i_rst_n, .i_start(w_gstart), .i_pos(i_in_data.pos_x),
                        .i_step(r_grid_step), .o_ctl(gctl_x), .o_grid(g_x));
    nsps_grid u_grid_y (.i_clk, .i_rst_n, .i_start(w_gstart), .i_pos(i_in_data.pos_y),
                        .i_step(r_grid_step), .o_ctl(gctl_y), .o_grid(g_y));
    nsps_grid u_grid_z (.i_clk, .i_rst_n, .i_start(w_gstart), .i_pos(i_in_data.pos_z),
                        .i_step(r_grid_step), .o_ctl(gctl_z), .o_grid(g_z));

    // Build the result
    always_comb begin
        n_out = '0;
        if (r_snap_en) begin
            if (r_found && r_best_d < nsps_pkg::SumBits'(r_tol2)) begin
                n_out.snapped     = 1'b1;
                n_out.snap_kind   = 3'(r_best_k) + 3'd1;
                n_out.snap_x      = rd_x;
                n_out.snap_y      = rd_y;
                n_out.snap_z      = rd_z;
                n_out.hit_mesh    = rd_mesh;
                n_out.hit_element = rd_elem;
                n_out.dist_sq     = nsps_pkg::DistBits'(r_best_d);
            end else if (r_grid_en && r_dsum < nsps_pkg::SumBits'(r_tol2)) begin
                n_out.snapped   = 1'b1;
                n_out.snap_kind = nsps_pkg::SK_GRID;
                n_out.snap_x    = g_x;
                n_out.snap_y    = g_y;
                n_out.snap_z    = g_z;
                n_out.dist_sq   = nsps_pkg::DistBits'(r_dsum);
            end
        end
    end

    // Output register: load on the last query cycle, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == nsps_pkg::ST_DONE && (!r_out_vld || !i_out_stall)) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (r_state == nsps_pkg::ST_DONE && (!r_out_vld || !i_out_stall))
            r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `NSPS_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1,
        r_fill <= CB'(nsps_pkg::TableDepth), "fill count beyond table depth")
    `NSPS_ASSERT_IMP(a_grid_lockstep, i_clk, i_rst_n, 1'b1,
        gctl_x.busy == gctl_y.busy && gctl_y.busy == gctl_z.busy, "grid units out of step")
    `NSPS_ASSERT_NEXT(a_remove_shrinks, i_clk, i_rst_n,
        r_state == nsps_pkg::ST_RM_SCAN, r_wr_cnt <= r_fill, "compaction passed fill count")
endmodule

// File: sv/nsps_grid.sv
// Grid rounding unit: one coordinate rounded to the nearest grid point by
// restoring division, one quotient bit a cycle. Depends on nsps_pkg.
module nsps_grid (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [nsps_pkg::CoordBits-1:0] i_pos,
    input  logic [nsps_pkg::StepBits-1:0]        i_step,
    output nsps_pkg::t_grid_ctl                  o_ctl,
    output logic signed [nsps_pkg::CoordBits-1:0] o_grid
);
    localparam int NumBits = nsps_pkg::CoordBits + 1;      // 2*|p| + step
    localparam int DenBits = nsps_pkg::StepBits + 1;       // 2*step
    localparam int CntBits = $clog2(NumBits + 1);
    localparam int ProdBits = NumBits + nsps_pkg::StepBits;

    logic [NumBits-1:0]   r_num, n_num;
    logic [DenBits-1:0]   r_den;
    logic [DenBits:0]     r_rem, n_rem;
    logic [NumBits-1:0]   r_quo, n_quo;
    logic [CntBits-1:0]   r_cnt;
    logic                 r_busy, r_mul, r_done, r_neg;
    logic [nsps_pkg::StepBits-1:0] r_step;
    logic [ProdBits-1:0]  r_prod;
    logic [DenBits:0]     w_trial;
    logic [nsps_pkg::CoordBits:0] w_abs;
    logic [nsps_pkg::StepBits-1:0] w_step;

    assign w_step = (i_step == '0) ? nsps_pkg::StepBits'(1) : i_step;
    assign w_abs  = i_pos[nsps_pkg::CoordBits-1]
                  ? (nsps_pkg::CoordBits+1)'(-{i_pos[nsps_pkg::CoordBits-1], i_pos})
                  : {1'b0, i_pos};

    // One restoring division step
    always_comb begin
        w_trial = {r_rem[DenBits-1:0], r_num[NumBits-1]};
        n_num   = {r_num[NumBits-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_quo = {r_quo[NumBits-2:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_quo = {r_quo[NumBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntBits'(NumBits);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntBits'(1)) begin
                    r_busy <= 1'b0;
                    r_mul  <= 1'b1;
                end
            end else if (r_mul) begin
                r_mul  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: load, iterate, multiply back
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= NumBits'({w_abs, 1'b0}) + NumBits'(w_step);
            r_den  <= {w_step, 1'b0};
            r_rem  <= '0;
            r_quo  <= '0;
            r_neg  <= i_pos[nsps_pkg::CoordBits-1];
            r_step <= w_step;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end else if (r_mul) begin
            r_prod <= ProdBits'(r_quo) * ProdBits'(r_step);
        end
    end

    // Saturate to the signed coordinate range
    always_comb begin
        if (r_neg) begin
            if (r_prod > ProdBits'(1 << (nsps_pkg::CoordBits - 1)))
                o_grid = {1'b1, {(nsps_pkg::CoordBits-1){1'b0}}};
            else
                o_grid = nsps_pkg::CoordBits'(-r_prod);
        end else begin
            if (r_prod > ProdBits'((1 << (nsps_pkg::CoordBits - 1)) - 1))
                o_grid = {1'b0, {(nsps_pkg::CoordBits-1){1'b1}}};
            else
                o_grid = nsps_pkg::CoordBits'(r_prod);
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy | r_mul;
    assign o_ctl.done  = r_done;
endmodule
